// ===== hdl/scmt_pkg.sv =====
// ----------------------------------------------------------------------------
// scmt_pkg
// Shared types, codes and constants of the sensor condition monitor table.
// ----------------------------------------------------------------------------
`default_nettype none

package scmt_pkg;

    localparam int MONITOR_SLOTS_DEF = 8;
    localparam int DEVICE_COUNT_DEF  = 16;

    localparam int PCT_FULL     = 100;
    localparam int REF_MIN      = 5;
    localparam int REF_FALLBACK = 255;

    // raw reading times full percentage fits in this many bits
    localparam int DIVIDEND_W = 15;
    localparam int DIVISOR_W  = 8;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_SCAN   = 2'd3;

    localparam logic [2:0] KIND_ON      = 3'd0;
    localparam logic [2:0] KIND_OFF     = 3'd1;
    localparam logic [2:0] KIND_CHANGE  = 3'd2;
    localparam logic [2:0] KIND_EQUAL   = 3'd3;
    localparam logic [2:0] KIND_GREATER = 3'd4;
    localparam logic [2:0] KIND_LESS    = 3'd5;

    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_FIRED  = 2'd1;
    localparam logic [1:0] RK_DONE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [7:0]  tag;
        logic [2:0]  kind;
        logic [3:0]  target;
        logic [7:0]  compare;
        logic [15:0] action;
        logic        previous;
    } slot_entry_t;

    typedef struct packed {
        logic wr_en;
        logic set_valid;
        logic clr_valid;
        logic rd_en;
    } slot_ctl_t;

    typedef struct packed {
        logic       is_on;
        logic [7:0] reading;
    } dev_entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } dev_ctl_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sensor_condition_monitor_table.sv =====
// ----------------------------------------------------------------------------
// sensor_condition_monitor_table
// Table of condition monitors over per-device on/off state and readings.
// Commands update a device, start or stop a monitor, or scan all monitors.
//
//   channel   signals                                   handshake
//   --------  ----------------------------------------  -------------------
//   command   start, busy, opcode .. action_code        start && !busy
//   result    result_valid, result_kind .. last_of_run  one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_data            cfg_valid && ready
//
// update and start finish in the idle state; their result follows on the next cycle
// stop walks the slot memory until the tag matches or the last slot is checked
// scan reads the reference device, then per slot the slot and, if valid, its
// device, waiting on the divider for value monitors; then the finish item
// reset clears all slot and device flags; results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_condition_monitor_table #(
    parameter int MONITOR_SLOTS = scmt_pkg::MONITOR_SLOTS_DEF,
    parameter int DEVICE_COUNT  = scmt_pkg::DEVICE_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  device_index,
    input  wire logic        device_is_on,
    input  wire logic [7:0]  raw_reading,
    input  wire logic [7:0]  monitor_tag,
    input  wire logic [2:0]  monitor_kind,
    input  wire logic [3:0]  target_device,
    input  wire logic [7:0]  compare_value,
    input  wire logic [15:0] action_code,
    output logic             result_valid,
    output logic      [1:0]  result_kind,
    output logic      [1:0]  status_code,
    output logic      [15:0] fired_action,
    output logic      [2:0]  fired_slot,
    output logic             last_of_run,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data
);
    import scmt_pkg::*;

    localparam int SW      = idx_w(MONITOR_SLOTS);
    localparam int DW      = idx_w(DEVICE_COUNT);
    localparam int SLOT_XW = (SW > 3) ? SW : 3;
    localparam int DEV_XW  = (DW > 4) ? DW : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STOP_CHK,
        S_SCAN_REF,
        S_SCAN_SLOT,
        S_SCAN_DEV,
        S_SCAN_DIV,
        S_SCAN_NEXT
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] action;
        logic [2:0]  slot;
        logic        last;
    } result_t;

    state_t      state_reg, state_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  ref_reg, ref_next;
    logic [3:0]  ref_dev_reg;
    slot_entry_t entry_reg, entry_next;
    result_t     res_reg, res_next;

    slot_ctl_t   slot_ctl;
    logic [SW-1:0] slot_wr_addr, slot_rd_addr;
    slot_entry_t slot_wr_data, slot_rd_data;
    logic        slot_rd_valid, free_found;
    logic [SW-1:0] free_addr;

    dev_ctl_t    dev_ctl;
    logic [DW-1:0] dev_wr_addr, dev_rd_addr;
    dev_entry_t  dev_wr_data, dev_rd_data;

    logic                  div_start, div_done;
    logic [DIVIDEND_W-1:0] div_dividend, div_quotient;

    function automatic logic [DW-1:0] to_dev_addr(input logic [3:0] d);
        logic [DEV_XW-1:0] w;
        w = DEV_XW'(d);
        return w[DW-1:0];
    endfunction

    function automatic logic [2:0] to_slot_field(input logic [SW-1:0] s);
        logic [SLOT_XW-1:0] w;
        w = SLOT_XW'(s);
        return w[2:0];
    endfunction

    scmt_slot_store #(
        .MONITOR_SLOTS(MONITOR_SLOTS)
    ) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (slot_ctl),
        .wr_addr   (slot_wr_addr),
        .wr_data   (slot_wr_data),
        .rd_addr   (slot_rd_addr),
        .rd_data   (slot_rd_data),
        .rd_valid  (slot_rd_valid),
        .free_found(free_found),
        .free_addr (free_addr)
    );

    scmt_dev_store #(
        .DEVICE_COUNT(DEVICE_COUNT)
    ) u_devs (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (dev_ctl),
        .wr_addr(dev_wr_addr),
        .wr_data(dev_wr_data),
        .rd_addr(dev_rd_addr),
        .rd_data(dev_rd_data)
    );

    scmt_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (ref_reg),
        .done    (div_done),
        .quotient(div_quotient)
    );

    always_comb
    begin
        slot_entry_t upd;
        logic        idx_last;
        logic        st;
        logic        fire;
        logic        cond;
        logic [7:0]  pct;
        logic [7:0]  ref_raw;

        state_next = state_reg;
        idx_next   = idx_reg;
        tag_next   = tag_reg;
        ref_next   = ref_reg;
        entry_next = entry_reg;
        res_next   = res_reg;
        res_next.valid = 1'b0;

        slot_ctl     = '0;
        slot_wr_addr = idx_reg;
        slot_wr_data = entry_reg;
        slot_rd_addr = idx_reg;
        dev_ctl      = '0;
        dev_wr_addr  = to_dev_addr(device_index);
        dev_wr_data  = '{is_on: device_is_on, reading: raw_reading};
        dev_rd_addr  = to_dev_addr(ref_dev_reg);
        div_start    = 1'b0;
        div_dividend = DIVIDEND_W'(dev_rd_data.reading) * DIVIDEND_W'(PCT_FULL);

        upd      = entry_reg;
        idx_last = idx_reg == SW'(MONITOR_SLOTS - 1);
        st       = dev_rd_data.is_on;
        fire     = 1'b0;
        cond     = 1'b0;
        pct      = (div_quotient > DIVIDEND_W'(PCT_FULL)) ? 8'(PCT_FULL)
                                                          : div_quotient[7:0];
        ref_raw  = (int'(ref_dev_reg) < DEVICE_COUNT) ? dev_rd_data.reading : 8'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_UPDATE:
                        begin
                            dev_ctl.wr_en = int'(device_index) < DEVICE_COUNT;
                            res_next = '{1'b1, RK_STATUS, ST_OK, 16'd0, 3'd0, 1'b1};
                        end
                        OP_START:
                        begin
                            if (free_found)
                            begin
                                slot_ctl.wr_en     = 1'b1;
                                slot_ctl.set_valid = 1'b1;
                                slot_wr_addr       = free_addr;
                                slot_wr_data       = '{tag: monitor_tag,
                                                       kind: monitor_kind,
                                                       target: target_device,
                                                       compare: compare_value,
                                                       action: action_code,
                                                       previous: 1'b0};
                                res_next = '{1'b1, RK_STATUS, ST_OK, 16'd0, 3'd0, 1'b1};
                            end
                            else
                            begin
                                res_next = '{1'b1, RK_STATUS, ST_FULL, 16'd0, 3'd0, 1'b1};
                            end
                        end
                        OP_STOP:
                        begin
                            tag_next       = monitor_tag;
                            idx_next       = '0;
                            slot_ctl.rd_en = 1'b1;
                            slot_rd_addr   = '0;
                            state_next     = S_STOP_CHK;
                        end
                        default:
                        begin
                            dev_ctl.rd_en = 1'b1;
                            state_next    = S_SCAN_REF;
                        end
                    endcase
                end
            end
            S_STOP_CHK:
            begin
                if (slot_rd_valid && slot_rd_data.tag == tag_reg)
                begin
                    slot_ctl.clr_valid = 1'b1;
                    res_next   = '{1'b1, RK_STATUS, ST_OK, 16'd0, 3'd0, 1'b1};
                    state_next = S_IDLE;
                end
                else if (idx_last)
                begin
                    res_next   = '{1'b1, RK_STATUS, ST_NOT_FOUND, 16'd0, 3'd0, 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next       = idx_reg + 1'b1;
                    slot_rd_addr   = idx_reg + 1'b1;
                    slot_ctl.rd_en = 1'b1;
                end
            end
            S_SCAN_REF:
            begin
                ref_next       = (int'(ref_raw) < REF_MIN) ? 8'(REF_FALLBACK) : ref_raw;
                idx_next       = '0;
                slot_rd_addr   = '0;
                slot_ctl.rd_en = 1'b1;
                state_next     = S_SCAN_SLOT;
            end
            S_SCAN_SLOT:
            begin
                entry_next = slot_rd_data;
                if (slot_rd_valid && int'(slot_rd_data.target) < DEVICE_COUNT &&
                    slot_rd_data.kind <= KIND_LESS)
                begin
                    dev_rd_addr   = to_dev_addr(slot_rd_data.target);
                    dev_ctl.rd_en = 1'b1;
                    state_next    = S_SCAN_DEV;
                end
                else
                begin
                    state_next = S_SCAN_NEXT;
                end
            end
            S_SCAN_DEV:
            begin
                if (entry_reg.kind <= KIND_CHANGE)
                begin
                    fire = (st != entry_reg.previous) &&
                           ((entry_reg.kind == KIND_CHANGE) ||
                            (entry_reg.kind == KIND_ON && st) ||
                            (entry_reg.kind == KIND_OFF && !st));
                    upd.previous   = st;
                    slot_wr_data   = upd;
                    slot_ctl.wr_en = 1'b1;
                    if (fire)
                    begin
                        res_next = '{1'b1, RK_FIRED, ST_OK, entry_reg.action,
                                     to_slot_field(idx_reg), 1'b0};
                    end
                    state_next = S_SCAN_NEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_SCAN_DIV;
                end
            end
            S_SCAN_DIV:
            begin
                if (div_done)
                begin
                    case (entry_reg.kind)
                        KIND_EQUAL:   cond = entry_reg.compare == pct;
                        KIND_GREATER: cond = pct > entry_reg.compare;
                        default:      cond = pct < entry_reg.compare;
                    endcase
                    fire           = cond && !entry_reg.previous;
                    upd.previous   = cond;
                    slot_wr_data   = upd;
                    slot_ctl.wr_en = 1'b1;
                    if (fire)
                    begin
                        res_next = '{1'b1, RK_FIRED, ST_OK, entry_reg.action,
                                     to_slot_field(idx_reg), 1'b0};
                    end
                    state_next = S_SCAN_NEXT;
                end
            end
            S_SCAN_NEXT:
            begin
                if (idx_last)
                begin
                    res_next   = '{1'b1, RK_DONE, ST_OK, 16'd0, 3'd0, 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next       = idx_reg + 1'b1;
                    slot_rd_addr   = idx_reg + 1'b1;
                    slot_ctl.rd_en = 1'b1;
                    state_next     = S_SCAN_SLOT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            tag_reg     <= '0;
            ref_reg     <= '0;
            entry_reg   <= '0;
            res_reg     <= '0;
            ref_dev_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            tag_reg   <= tag_next;
            ref_reg   <= ref_next;
            entry_reg <= entry_next;
            res_reg   <= res_next;
            if (cfg_valid)
            begin
                ref_dev_reg <= cfg_data;
            end
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign cfg_ready    = 1'b1;
    assign result_valid = res_reg.valid;
    assign result_kind  = res_reg.kind;
    assign status_code  = res_reg.status;
    assign fired_action = res_reg.action;
    assign fired_slot   = res_reg.slot;
    assign last_of_run  = res_reg.last;

endmodule

`default_nettype wire

// ===== hdl/scmt_divider.sv =====
// ----------------------------------------------------------------------------
// scmt_divider
// Restoring divider, one quotient bit per cycle, pulses done when finished.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [scmt_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [scmt_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                 done,
    output logic      [scmt_pkg::DIVIDEND_W-1:0] quotient
);
    import scmt_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = shifted >= {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DIVISOR_W'(shifted - {1'b0, div_reg})
                            : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/scmt_slot_store.sv =====
// ----------------------------------------------------------------------------
// scmt_slot_store
// Monitor slot memory with registered read, plus per-slot valid flags and
// first-free search.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_slot_store #(
    parameter int MONITOR_SLOTS = scmt_pkg::MONITOR_SLOTS_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire scmt_pkg::slot_ctl_t                           ctl,
    input  wire logic [scmt_pkg::idx_w(MONITOR_SLOTS)-1:0]     wr_addr,
    input  wire scmt_pkg::slot_entry_t                         wr_data,
    input  wire logic [scmt_pkg::idx_w(MONITOR_SLOTS)-1:0]     rd_addr,
    output scmt_pkg::slot_entry_t                              rd_data,
    output logic                                               rd_valid,
    output logic                                               free_found,
    output logic      [scmt_pkg::idx_w(MONITOR_SLOTS)-1:0]     free_addr
);
    import scmt_pkg::*;

    localparam int SW = idx_w(MONITOR_SLOTS);

    slot_entry_t              mem [MONITOR_SLOTS];
    slot_entry_t              rd_data_reg;
    logic                     rd_valid_reg;
    logic [MONITOR_SLOTS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (ctl.clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // lowest free slot wins
    always_comb
    begin
        free_found = 1'b0;
        free_addr  = '0;
        for (int i = MONITOR_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_addr  = SW'(i);
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/scmt_dev_store.sv =====
// ----------------------------------------------------------------------------
// scmt_dev_store
// Device state memory with registered read; unwritten devices read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_dev_store #(
    parameter int DEVICE_COUNT = scmt_pkg::DEVICE_COUNT_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire scmt_pkg::dev_ctl_t                         ctl,
    input  wire logic [scmt_pkg::idx_w(DEVICE_COUNT)-1:0]   wr_addr,
    input  wire scmt_pkg::dev_entry_t                       wr_data,
    input  wire logic [scmt_pkg::idx_w(DEVICE_COUNT)-1:0]   rd_addr,
    output scmt_pkg::dev_entry_t                            rd_data
);
    import scmt_pkg::*;

    dev_entry_t              mem [DEVICE_COUNT];
    dev_entry_t              rd_data_reg;
    logic                    rd_valid_reg;
    logic [DEVICE_COUNT-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== hdl/scmt_checker.sv =====
// ----------------------------------------------------------------------------
// scmt_checker
// Port-level checks of the monitor table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] opcode,
    input wire logic       result_valid,
    input wire logic [1:0] result_kind,
    input wire logic [1:0] status_code,
    input wire logic       last_of_run
);
    import scmt_pkg::*;

    // update answers on the very next cycle and ends its run
    a_update_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_UPDATE |=>
            result_valid && result_kind == RK_STATUS && last_of_run)
        else $error("update item without immediate status");

    // stop and scan keep the block busy and answer later
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == OP_STOP || opcode == OP_SCAN) |=>
            busy && !result_valid)
        else $error("stop or scan answered without a walk");

    // only firings are mid-run, and the run is still going
    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |-> busy && result_kind == RK_FIRED)
        else $error("mid-run result outside a scan");

    a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind != RK_STATUS |-> status_code == ST_OK)
        else $error("nonzero status on a scan result");

endmodule

bind sensor_condition_monitor_table scmt_checker u_scmt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .result_valid(result_valid),
    .result_kind (result_kind),
    .status_code (status_code),
    .last_of_run (last_of_run)
);

`default_nettype wire

// ===== test/sensor_condition_monitor_table_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_condition_monitor_table_tb
// Drives update, start, stop and scan commands into the monitor table, keeps
// its own copy of the slot table, device states and reference device, and
// checks every result strobe against the predicted sequence.
// ----------------------------------------------------------------------------
module sensor_condition_monitor_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scmt_pkg::*;

    localparam int SLOTS       = MONITOR_SLOTS_DEF;
    localparam int DEVICES     = DEVICE_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 50;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  device;
        logic        is_on;
        logic [7:0]  raw;
        logic [7:0]  tag;
        logic [2:0]  kind;
        logic [3:0]  target;
        logic [7:0]  compare;
        logic [15:0] action;
    } command_t;

    typedef struct packed {
        logic [1:0]  rkind;
        logic [1:0]  status;
        logic [15:0] action;
        logic [2:0]  slot;
        logic        last;
    } monitor_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [3:0]  device_index;
    logic        device_is_on;
    logic [7:0]  raw_reading;
    logic [7:0]  monitor_tag;
    logic [2:0]  monitor_kind;
    logic [3:0]  target_device;
    logic [7:0]  compare_value;
    logic [15:0] action_code;
    logic        result_valid;
    logic [1:0]  result_kind;
    logic [1:0]  status_code;
    logic [15:0] fired_action;
    logic [2:0]  fired_slot;
    logic        last_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    bit          mon_valid   [SLOTS];
    bit [7:0]    mon_tag     [SLOTS];
    bit [2:0]    mon_kind    [SLOTS];
    bit [3:0]    mon_target  [SLOTS];
    bit [7:0]    mon_compare [SLOTS];
    bit [15:0]   mon_action  [SLOTS];
    bit          mon_previous[SLOTS];
    bit          dev_on      [DEVICES];
    bit [7:0]    dev_reading [DEVICES];
    bit [3:0]    ref_dev;

    monitor_result_t expected_results[$];
    int          error_count;
    int          idle_cycles;
    bit          gaps_enabled;

    sensor_condition_monitor_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .device_index  (device_index),
        .device_is_on  (device_is_on),
        .raw_reading   (raw_reading),
        .monitor_tag   (monitor_tag),
        .monitor_kind  (monitor_kind),
        .target_device (target_device),
        .compare_value (compare_value),
        .action_code   (action_code),
        .result_valid  (result_valid),
        .result_kind   (result_kind),
        .status_code   (status_code),
        .fired_action  (fired_action),
        .fired_slot    (fired_slot),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int normalized_percent(input bit [7:0] raw);
        int divisor;
        int pct;
        divisor = int'(dev_reading[ref_dev]);
        if (divisor < REF_MIN)
            divisor = REF_FALLBACK;
        pct = (int'(raw) * PCT_FULL) / divisor;
        return (pct > PCT_FULL) ? PCT_FULL : pct;
    endfunction

    task automatic predict_results(input command_t c);
        monitor_result_t r;
        bit              found;
        bit              fire;
        bit              cond;
        bit              st;
        int              pct;
        r        = '0;
        r.rkind  = RK_STATUS;
        r.status = ST_OK;
        r.last   = 1'b1;
        found    = 1'b0;
        case (c.opcode)
            OP_UPDATE: begin
                dev_on[c.device]      = c.is_on;
                dev_reading[c.device] = c.raw;
                expected_results.push_back(r);
            end
            OP_START: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !mon_valid[i]) begin
                        found           = 1'b1;
                        mon_valid[i]    = 1'b1;
                        mon_tag[i]      = c.tag;
                        mon_kind[i]     = c.kind;
                        mon_target[i]   = c.target;
                        mon_compare[i]  = c.compare;
                        mon_action[i]   = c.action;
                        mon_previous[i] = 1'b0;
                    end
                end
                if (!found)
                    r.status = ST_FULL;
                expected_results.push_back(r);
            end
            OP_STOP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && mon_valid[i] && mon_tag[i] == c.tag) begin
                        found           = 1'b1;
                        mon_valid[i]    = 1'b0;
                        mon_tag[i]      = '0;
                        mon_kind[i]     = '0;
                        mon_target[i]   = '0;
                        mon_compare[i]  = '0;
                        mon_action[i]   = '0;
                        mon_previous[i] = 1'b0;
                    end
                end
                if (!found)
                    r.status = ST_NOT_FOUND;
                expected_results.push_back(r);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    fire = 1'b0;
                    if (mon_valid[i]) begin
                        if (mon_kind[i] <= KIND_CHANGE) begin
                            st = dev_on[mon_target[i]];
                            if (st != mon_previous[i])
                                fire = (mon_kind[i] == KIND_CHANGE) ||
                                       (mon_kind[i] == KIND_ON && st) ||
                                       (mon_kind[i] == KIND_OFF && !st);
                            mon_previous[i] = st;
                        end else if (mon_kind[i] <= KIND_LESS) begin
                            pct = normalized_percent(dev_reading[mon_target[i]]);
                            if (mon_kind[i] == KIND_EQUAL)
                                cond = (int'(mon_compare[i]) == pct);
                            else if (mon_kind[i] == KIND_GREATER)
                                cond = (pct > int'(mon_compare[i]));
                            else
                                cond = (pct < int'(mon_compare[i]));
                            fire            = cond && !mon_previous[i];
                            mon_previous[i] = cond;
                        end
                    end
                    if (fire) begin
                        r        = '0;
                        r.rkind  = RK_FIRED;
                        r.action = mon_action[i];
                        r.slot   = 3'(i);
                        expected_results.push_back(r);
                    end
                end
                r       = '0;
                r.rkind = RK_DONE;
                r.last  = 1'b1;
                expected_results.push_back(r);
            end
        endcase
    endtask

    task automatic issue_command(input command_t c);
        @(negedge clk);
        while (gaps_enabled && $urandom_range(99) < 22) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start         <= 1'b1;
        opcode        <= c.opcode;
        device_index  <= c.device;
        device_is_on  <= c.is_on;
        raw_reading   <= c.raw;
        monitor_tag   <= c.tag;
        monitor_kind  <= c.kind;
        target_device <= c.target;
        compare_value <= c.compare;
        action_code   <= c.action;
        do
            @(posedge clk);
        while (busy);
        predict_results(c);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reference_device(input logic [3:0] dev);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= dev;
        do
            @(posedge clk);
        while (!cfg_ready);
        ref_dev = dev;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic command_t cmd(input logic [1:0] op, input logic [3:0] dev,
                                     input logic on, input logic [7:0] raw,
                                     input logic [7:0] tag, input logic [2:0] kind,
                                     input logic [3:0] tgt, input logic [7:0] cmp,
                                     input logic [15:0] act);
        command_t c;
        c = '{op, dev, on, raw, tag, kind, tgt, cmp, act};
        return c;
    endfunction

    function automatic command_t random_command();
        command_t c;
        int       pick;
        c.opcode  = 2'($urandom);
        c.device  = ($urandom_range(4) == 0) ? ref_dev : 4'($urandom);
        c.is_on   = 1'($urandom);
        c.raw     = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(60));
        c.tag     = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : 8'($urandom);
        c.kind    = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(KIND_LESS));
        c.target  = 4'($urandom);
        c.compare = ($urandom_range(1) == 0) ? 8'($urandom_range(PCT_FULL))
                                             : 8'($urandom);
        c.action  = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)
            c.opcode = OP_UPDATE;
        else if (pick < 60)
            c.opcode = OP_START;
        else if (pick < 75)
            c.opcode = OP_STOP;
        else
            c.opcode = OP_SCAN;
        return c;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            issue_command(random_command());
    endtask

    task automatic test_commands_directed();
        gaps_enabled = 1'b1;
        issue_command(cmd(OP_SCAN,   0,  0, 0,   0,   0,            0,  0,   0));
        issue_command(cmd(OP_UPDATE, 15, 1, 255, 0,   0,            0,  0,   0));
        // reference reading below the minimum falls back to full scale
        issue_command(cmd(OP_UPDATE, 0,  0, 4,   0,   0,            0,  0,   0));
        issue_command(cmd(OP_START,  0,  0, 0,   0,   KIND_ON,      15, 0,   16'hFFFF));
        issue_command(cmd(OP_START,  0,  0, 0,   255, KIND_OFF,     0,  0,   16'h0000));
        issue_command(cmd(OP_START,  0,  0, 0,   1,   KIND_CHANGE,  15, 0,   16'h1234));
        issue_command(cmd(OP_START,  0,  0, 0,   2,   KIND_EQUAL,   15, 100, 16'hA5A5));
        issue_command(cmd(OP_START,  0,  0, 0,   3,   KIND_GREATER, 3,  0,   16'h5A5A));
        issue_command(cmd(OP_START,  0,  0, 0,   4,   KIND_LESS,    3,  255, 16'h0F0F));
        issue_command(cmd(OP_START,  0,  0, 0,   5,   3'd6,         15, 0,   16'h0606));
        issue_command(cmd(OP_START,  0,  0, 0,   6,   3'd7,         0,  0,   16'h0707));
        // table full
        issue_command(cmd(OP_START,  0,  0, 0,   7,   KIND_ON,      1,  0,   16'h7777));
        issue_command(cmd(OP_SCAN,   0,  0, 0,   0,   0,            0,  0,   0));
        issue_command(cmd(OP_SCAN,   0,  0, 0,   0,   0,            0,  0,   0));
        issue_command(cmd(OP_UPDATE, 15, 0, 0,   0,   0,            0,  0,   0));
        issue_command(cmd(OP_UPDATE, 0,  1, 255, 0,   0,            0,  0,   0));
        issue_command(cmd(OP_SCAN,   0,  0, 0,   0,   0,            0,  0,   0));
        issue_command(cmd(OP_STOP,   0,  0, 0,   99,  0,            0,  0,   0));
        issue_command(cmd(OP_STOP,   0,  0, 0,   255, 0,            0,  0,   0));
        issue_command(cmd(OP_STOP,   0,  0, 0,   255, 0,            0,  0,   0));
        issue_command(cmd(OP_START,  0,  0, 0,   200, KIND_GREATER, 0,  50,  16'hBEEF));
        issue_command(cmd(OP_SCAN,   0,  0, 0,   0,   0,            0,  0,   0));
        // reference reading exactly at the minimum
        issue_command(cmd(OP_UPDATE, 0,  1, 5,   0,   0,            0,  0,   0));
        issue_command(cmd(OP_UPDATE, 3,  1, 255, 0,   0,            0,  0,   0));
        issue_command(cmd(OP_SCAN,   0,  0, 0,   0,   0,            0,  0,   0));
    endtask

    task automatic test_reference_top_device();
        write_reference_device(4'd15);
        gaps_enabled = 1'b1;
        run_random(140);
    endtask

    task automatic test_back_to_back();
        write_reference_device(4'($urandom_range(1, 14)));
        gaps_enabled = 1'b0;
        run_random(70);
        gaps_enabled = 1'b1;
        run_random(70);
    endtask

    task automatic test_reference_bottom_device();
        write_reference_device(4'd0);
        gaps_enabled = 1'b1;
        run_random(125);
    endtask

    always @(posedge clk) begin : result_checker
        monitor_result_t exp;
        if (rst_n && result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d slot %0d",
                                          result_kind, fired_slot));
            end else begin
                exp = expected_results.pop_front();
                if (result_kind !== exp.rkind)
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              result_kind, exp.rkind));
                if (status_code !== exp.status)
                    report_mismatch($sformatf("status_code %0d, expected %0d",
                                              status_code, exp.status));
                if (fired_action !== exp.action)
                    report_mismatch($sformatf("fired_action %h, expected %h",
                                              fired_action, exp.action));
                if (fired_slot !== exp.slot)
                    report_mismatch($sformatf("fired_slot %0d, expected %0d",
                                              fired_slot, exp.slot));
                if (last_of_run !== exp.last)
                    report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                              last_of_run, exp.last));
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** sensor_condition_monitor_table: FAILED **");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        gaps_enabled  = 1'b1;
        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_UPDATE;
        device_index  = '0;
        device_is_on  = 1'b0;
        raw_reading   = '0;
        monitor_tag   = '0;
        monitor_kind  = KIND_ON;
        target_device = '0;
        compare_value = '0;
        action_code   = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_commands_directed();
        test_reference_top_device();
        test_back_to_back();
        test_reference_bottom_device();

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_results.size()));
        if (error_count == 0)
            $display("** sensor_condition_monitor_table: PASSED **");
        else
            $display("** sensor_condition_monitor_table: FAILED **");
        $finish;
    end

endmodule
